FILE: rtl/hotp_pkg.sv
// ----------------------------------------------------------------------------
// hotp_pkg
// Shared types and constants for the HMAC-SHA1 one-time password generator.
// ----------------------------------------------------------------------------
package hotp_pkg;

    localparam int unsigned KeyWords = 8;
    localparam int unsigned CfgIdxW  = 3;

    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hefcdab89;
    localparam logic [31:0] H2 = 32'h98badcfe;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hc3d2e1f0;

    localparam logic [31:0] IPAD = 32'h36363636;
    localparam logic [31:0] OPAD = 32'h5c5c5c5c;

    // decimal moduli and floor(2^32 / modulus) for the quotient estimate
    localparam logic [26:0] MOD_D6   = 27'd1000000;
    localparam logic [26:0] MOD_D7   = 27'd10000000;
    localparam logic [26:0] MOD_D8   = 27'd100000000;
    localparam logic [12:0] RECIP_D6 = 13'd4294;
    localparam logic [12:0] RECIP_D7 = 13'd429;
    localparam logic [12:0] RECIP_D8 = 13'd42;

    // block select codes for the datapath message loader
    localparam logic [1:0] BLK_IKEY = 2'd0;
    localparam logic [1:0] BLK_CTR  = 2'd1;
    localparam logic [1:0] BLK_OKEY = 2'd2;
    localparam logic [1:0] BLK_DIG  = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic       load_in;   // capture counter and digit count
        logic       init_h;    // load initial chaining values
        logic       load_blk;  // load message block and working vars
        logic [1:0] blk_sel;
        logic       round;     // perform one round
        logic       fold;      // add working vars into chaining values
        logic       save_in;   // keep inner digest
        logic       trunc;     // dynamic truncation
        logic       mod_start; // quotient estimate by reciprocal multiply
        logic       mod_step;  // subtract quotient times modulus
        logic       mod_fix;   // final single correction
    } t_cmd;

    typedef struct packed {
        logic       bad_digits;
    } t_sts;

endpackage

FILE: rtl/hotp_datapath.sv
// ----------------------------------------------------------------------------
// hotp_datapath
// SHA-1 round unit with a 16-word schedule window, HMAC chaining registers,
// dynamic truncation and a three-step reciprocal-multiply remainder unit.
// ----------------------------------------------------------------------------
module hotp_datapath (
    input  logic                    i_clk,
    input  hotp_pkg::t_cmd          i_cmd,
    output hotp_pkg::t_sts          o_sts,
    input  logic [63:0]             i_key [hotp_pkg::KeyWords],
    input  logic [63:0]             i_counter_value,
    input  logic [3:0]              i_digit_count,
    output logic [26:0]             o_otp_value
);
    import hotp_pkg::*;

    logic [63:0]  r_ctr;
    logic [3:0]   r_nd;
    logic [31:0]  r_h [5];
    logic [31:0]  r_ih [5];
    logic [31:0]  r_a, r_b, r_c, r_d, r_e;
    logic [31:0]  r_w [16];
    logic [6:0]   r_t;
    logic [30:0]  r_bin;
    logic [26:0]  r_mod;
    logic [12:0]  r_recip;
    logic [11:0]  r_q;
    logic [27:0]  r_rem;

    logic [31:0] blk [16];
    logic [31:0] f, kc, tmp, wn;
    logic [31:0] pad;
    logic [159:0] dig;
    logic [30:0] bin;
    logic [3:0]  off;
    logic [43:0] prod_q;
    logic [30:0] prod_m;

    // message block selection
    always_comb begin
        pad = (i_cmd.blk_sel == BLK_OKEY) ? OPAD : IPAD;
        for (int i = 0; i < 16; i++) blk[i] = '0;
        case (i_cmd.blk_sel)
            BLK_IKEY, BLK_OKEY: begin
                for (int i = 0; i < 8; i++) begin
                    blk[2*i]   = i_key[i][63:32] ^ pad;
                    blk[2*i+1] = i_key[i][31:0] ^ pad;
                end
            end
            BLK_CTR: begin
                blk[0]  = r_ctr[63:32];
                blk[1]  = r_ctr[31:0];
                blk[2]  = 32'h80000000;
                blk[15] = 32'd576;
            end
            BLK_DIG: begin
                for (int i = 0; i < 5; i++) blk[i] = r_ih[i];
                blk[5]  = 32'h80000000;
                blk[15] = 32'd672;
            end
            default: ;
        endcase
    end

    // round function
    always_comb begin
        if (r_t < 7'd20) begin
            f = (r_b & r_c) ^ (~r_b & r_d); kc = K0;
        end else if (r_t < 7'd40) begin
            f = r_b ^ r_c ^ r_d; kc = K1;
        end else if (r_t < 7'd60) begin
            f = (r_b & r_c) ^ (r_b & r_d) ^ (r_c & r_d); kc = K2;
        end else begin
            f = r_b ^ r_c ^ r_d; kc = K3;
        end
        tmp = {r_a[26:0], r_a[31:27]} + f + r_e + kc + r_w[0];
        wn  = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        wn  = {wn[30:0], wn[31]};
    end

    // truncation
    always_comb begin
        dig = {r_h[0], r_h[1], r_h[2], r_h[3], r_h[4]};
        off = dig[3:0];
        bin = 31'(dig >> (10'd128 - {off, 3'b000}));
    end

    // quotient estimate is exact or one low, so one correction suffices
    assign prod_q = {13'd0, r_bin} * {31'd0, r_recip};
    assign prod_m = 31'({19'd0, r_q} * {4'd0, r_mod});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_ctr <= i_counter_value;
            r_nd  <= i_digit_count;
        end
        if (i_cmd.init_h) begin
            r_h[0] <= H0; r_h[1] <= H1; r_h[2] <= H2; r_h[3] <= H3; r_h[4] <= H4;
        end
        if (i_cmd.load_blk) begin
            r_w <= blk;
            r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2]; r_d <= r_h[3]; r_e <= r_h[4];
            r_t <= '0;
        end
        if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= wn;
            r_e <= r_d; r_d <= r_c; r_c <= {r_b[1:0], r_b[31:2]};
            r_b <= r_a; r_a <= tmp;
            r_t <= r_t + 7'd1;
        end
        if (i_cmd.fold) begin
            r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b; r_h[2] <= r_h[2] + r_c;
            r_h[3] <= r_h[3] + r_d; r_h[4] <= r_h[4] + r_e;
        end
        if (i_cmd.save_in) r_ih <= r_h;
        // remainder: capture, estimate quotient, subtract, correct
        if (i_cmd.trunc) begin
            r_bin <= bin;
            case (r_nd)
                4'd6: begin
                    r_mod <= MOD_D6; r_recip <= RECIP_D6;
                end
                4'd7: begin
                    r_mod <= MOD_D7; r_recip <= RECIP_D7;
                end
                default: begin
                    r_mod <= MOD_D8; r_recip <= RECIP_D8;
                end
            endcase
        end
        if (i_cmd.mod_start) r_q <= prod_q[43:32];
        if (i_cmd.mod_step)  r_rem <= 28'(r_bin - prod_m);
        if (i_cmd.mod_fix) begin
            if (r_rem >= {1'b0, r_mod}) r_rem <= r_rem - {1'b0, r_mod};
        end
    end

    // status and result
    assign o_sts.bad_digits = (r_nd < 4'd6) || (r_nd > 4'd8);
    assign o_otp_value = o_sts.bad_digits ? '0 : r_rem[26:0];
endmodule

FILE: rtl/hotp_ctrl.sv
// ----------------------------------------------------------------------------
// hotp_ctrl
// Sequencer: four compressions of 80 rounds, truncation, three remainder steps.
// ----------------------------------------------------------------------------
module hotp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    output hotp_pkg::t_cmd o_cmd,
    input  hotp_pkg::t_sts i_sts
);
    import hotp_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_FOLD  = 3'd3;
    localparam logic [2:0] S_TRUNC = 3'd4;
    localparam logic [2:0] S_MOD   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] r_st, n_st;
    logic [1:0] r_blk, n_blk;
    logic [6:0] r_cnt, n_cnt;

    always_comb begin
        n_st = r_st; n_blk = r_blk; n_cnt = r_cnt;
        o_cmd = '0;
        o_cmd.blk_sel = r_blk;
        o_ready = (r_st == S_IDLE);
        o_valid = (r_st == S_OUT);
        case (r_st)
            S_IDLE: if (i_valid) begin
                o_cmd.load_in = 1'b1;
                o_cmd.init_h = 1'b1;
                n_blk = BLK_IKEY; n_st = S_LOAD;
            end
            S_LOAD: begin
                if (i_sts.bad_digits) n_st = S_OUT;
                else begin
                    o_cmd.load_blk = 1'b1; n_cnt = '0; n_st = S_ROUND;
                end
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd79) n_st = S_FOLD;
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                case (r_blk)
                    BLK_IKEY: begin n_blk = BLK_CTR; n_st = S_LOAD; end
                    BLK_CTR:  begin n_blk = BLK_OKEY; n_st = S_TRUNC; end
                    BLK_OKEY: begin n_blk = BLK_DIG; n_st = S_LOAD; end
                    default:  n_st = S_TRUNC;
                endcase
            end
            S_TRUNC: begin
                if (r_blk == BLK_OKEY) begin
                    // inner hash done: keep it and restart chaining for outer hash
                    o_cmd.save_in = 1'b1;
                    o_cmd.init_h = 1'b1; n_st = S_LOAD;
                end else begin
                    o_cmd.trunc = 1'b1;
                    n_cnt = '0; n_st = S_MOD;
                end
            end
            S_MOD: begin
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd0) o_cmd.mod_start = 1'b1;
                else if (r_cnt == 7'd1) o_cmd.mod_step = 1'b1;
                else begin
                    o_cmd.mod_fix = 1'b1; n_st = S_OUT;
                end
            end
            S_OUT: if (i_ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_blk <= BLK_IKEY; r_cnt <= '0;
        end else begin
            r_st <= n_st; r_blk <= n_blk; r_cnt <= n_cnt;
        end
    end
endmodule

FILE: rtl/hotp_hmac_sha1_generator.sv
// ----------------------------------------------------------------------------
// hotp_hmac_sha1_generator
// HMAC-SHA1 one-time password generator with dynamic truncation.
// ----------------------------------------------------------------------------
// channel | signals                         | direction
// in      | i_valid/o_ready, counter, digits | input
// out     | o_valid/i_ready, otp, status     | output
// cfg     | i_cfg_we, i_cfg_idx, i_cfg_data   | input
//
// after the input beat the sequencer runs four compressions of one load, 80
// rounds and one fold each, keeps the inner digest between the second and the
// third, then truncates and runs three remainder steps. a bad digit count
// skips hashing and goes from load to output. reset clears control and keys.
// the result is held until taken; input is accepted only when idle.
module hotp_hmac_sha1_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_counter_value,
    input  logic [3:0]  i_digit_count,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [26:0] o_otp_value,
    output logic        o_status,
    input  logic        i_cfg_we,
    input  logic [hotp_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [63:0] i_cfg_data
);
    import hotp_pkg::*;

    logic [63:0] r_key [KeyWords];
    t_cmd cmd;
    t_sts sts;

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KeyWords; i++) r_key[i] <= '0;
        end else if (i_cfg_we) begin
            r_key[i_cfg_idx] <= i_cfg_data;
        end
    end

    hotp_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
        .o_cmd(cmd), .i_sts(sts)
    );

    hotp_datapath u_dp (
        .i_clk, .i_cmd(cmd), .o_sts(sts), .i_key(r_key),
        .i_counter_value, .i_digit_count, .o_otp_value
    );

    assign o_status = sts.bad_digits;
endmodule

FILE: test/tb_hotp_hmac_sha1_generator.sv
// ----------------------------------------------------------------------------
// tb_hotp_hmac_sha1_generator
// Drives counter/digit-count requests through the one-time password generator
// under several keys, predicts each password with a behavioral HMAC-SHA1 and
// truncation, and compares every output beat in order.
// ----------------------------------------------------------------------------
module tb_hotp_hmac_sha1_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import hotp_pkg::*;

    typedef struct packed {
        logic [26:0] otp;
        logic        sts;
    } t_otp_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [63:0] i_counter_value;
    logic [3:0]  i_digit_count;
    logic        o_valid;
    logic        i_ready;
    logic [26:0] o_otp_value;
    logic        o_status;
    logic        i_cfg_we;
    logic [CfgIdxW-1:0] i_cfg_idx;
    logic [63:0] i_cfg_data;

    logic [63:0] key_reg [KeyWords];
    t_otp_res    otp_queue [$];
    int          n_errors;
    int          burst_left;

    hotp_hmac_sha1_generator u_dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #60ms;
        $display("FAIL");
        $finish;
    end

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // one sha-1 compression
    function automatic void sha1_compress(inout logic [31:0] h [5],
                                          input logic [31:0] blk [16]);
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, kc, tmp;
        for (int t = 0; t < 16; t++) w[t] = blk[t];
        for (int t = 16; t < 80; t++)
            w[t] = rotl(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
        a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
        for (int t = 0; t < 80; t++) begin
            if (t < 20) begin
                f = (b & c) ^ (~b & d); kc = K0;
            end else if (t < 40) begin
                f = b ^ c ^ d; kc = K1;
            end else if (t < 60) begin
                f = (b & c) ^ (b & d) ^ (c & d); kc = K2;
            end else begin
                f = b ^ c ^ d; kc = K3;
            end
            tmp = rotl(a, 5) + f + e + kc + w[t];
            e = d; d = c; c = rotl(b, 30); b = a; a = tmp;
        end
        h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
    endfunction

    // hmac over the counter, then dynamic truncation
    function automatic t_otp_res calc_otp(input logic [63:0] ctr, input logic [3:0] nd);
        logic [31:0] blk [16];
        logic [31:0] hi [5];
        logic [31:0] ho [5];
        logic [7:0]  dig [20];
        logic [31:0] bin;
        logic [31:0] modv;
        int          off;
        t_otp_res    r;
        r = '0;
        if (nd < 6 || nd > 8) begin
            r.sts = 1'b1;
            return r;
        end
        hi = '{H0, H1, H2, H3, H4};
        ho = hi;
        for (int i = 0; i < 8; i++) begin
            blk[2*i]   = key_reg[i][63:32] ^ IPAD;
            blk[2*i+1] = key_reg[i][31:0] ^ IPAD;
        end
        sha1_compress(hi, blk);
        foreach (blk[i]) blk[i] = '0;
        blk[0] = ctr[63:32]; blk[1] = ctr[31:0];
        blk[2] = 32'h80000000; blk[15] = 32'd576;
        sha1_compress(hi, blk);
        for (int i = 0; i < 8; i++) begin
            blk[2*i]   = key_reg[i][63:32] ^ OPAD;
            blk[2*i+1] = key_reg[i][31:0] ^ OPAD;
        end
        sha1_compress(ho, blk);
        foreach (blk[i]) blk[i] = '0;
        for (int i = 0; i < 5; i++) blk[i] = hi[i];
        blk[5] = 32'h80000000; blk[15] = 32'd672;
        sha1_compress(ho, blk);
        for (int i = 0; i < 5; i++)
            {dig[4*i], dig[4*i+1], dig[4*i+2], dig[4*i+3]} = ho[i];
        off = dig[19][3:0];
        bin = {1'b0, dig[off][6:0], dig[off+1], dig[off+2], dig[off+3]};
        modv = (nd == 6) ? 32'd1000000 : (nd == 7) ? 32'd10000000 : 32'd100000000;
        r.otp = 27'(bin % modv);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    // one request beat, sent in bursts with random gaps
    task automatic send_request(input logic [63:0] ctr, input logic [3:0] nd);
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0)
                repeat ($urandom_range(1, 400)) @(negedge i_clk);
        end
        burst_left--;
        i_valid         <= 1'b1;
        i_counter_value <= ctr;
        i_digit_count   <= nd;
        otp_queue.push_back(calc_otp(ctr, nd));
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // register write while idle
    task automatic write_key(input int idx, input logic [63:0] val);
        while (otp_queue.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CfgIdxW'(idx);
        i_cfg_data <= val;
        key_reg[idx] = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // receiver stall pattern and result check
    initial begin : result_check
        t_otp_res exp_res;
        int       phase;
        phase = 0;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                if (otp_queue.size() == 0) begin
                    report_mismatch("unexpected result beat");
                end else begin
                    exp_res = otp_queue.pop_front();
                    if (o_otp_value !== exp_res.otp)
                        report_mismatch($sformatf("otp %0d expected %0d",
                                        o_otp_value, exp_res.otp));
                    if (o_status !== exp_res.sts)
                        report_mismatch($sformatf("status %0b expected %0b",
                                        o_status, exp_res.sts));
                end
            end
            @(negedge i_clk);
            phase++;
            if (phase[12])
                i_ready <= 1'b1;
            else
                i_ready <= ($urandom_range(0, 3) != 0) || (phase[5:0] > 50);
        end
    end

    task automatic test_rfc_vectors();
        logic [63:0] ascii;
        ascii = 64'h3132333435363738;
        // rfc 4226 key "12345678901234567890"
        write_key(0, ascii);
        write_key(1, 64'h3930313233343536);
        write_key(2, {32'h37383930, 32'h0});
        for (int i = 3; i < 8; i++) write_key(i, '0);
        for (int c = 0; c < 10; c++) send_request(64'(c), 4'd6);
        send_request(64'd1, 4'd7);
        send_request(64'd2, 4'd8);
    endtask

    task automatic test_field_extremes();
        for (int nd = 0; nd < 16; nd++) send_request(64'hffff_ffff_ffff_ffff, 4'(nd));
        send_request(64'h0, 4'd8);
        send_request(64'h8000_0000_0000_0001, 4'd6);
    endtask

    task automatic test_key_extremes();
        for (int i = 0; i < 8; i++) write_key(i, '1);
        send_request(64'h0123_4567_89ab_cdef, 4'd8);
        send_request(64'hfedc_ba98_7654_3210, 4'd7);
        for (int i = 0; i < 8; i++) write_key(i, '0);
        send_request(64'h0, 4'd6);
        send_request(64'h5555_aaaa_5555_aaaa, 4'd8);
    endtask

    task automatic test_random_requests();
        logic [3:0] nd;
        for (int p = 0; p < 8; p++) begin
            for (int i = 0; i < 8; i++)
                write_key(i, (i < p + 2) ? {$urandom, $urandom} : 64'h0);
            for (int n = 0; n < 200; n++) begin
                nd = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(6, 8));
                send_request({$urandom, $urandom}, nd);
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0; i_valid = 1'b0;
        i_counter_value = '0; i_digit_count = '0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        n_errors = 0; burst_left = 0;
        foreach (key_reg[i]) key_reg[i] = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_rfc_vectors();
        test_field_extremes();
        test_key_extremes();
        test_random_requests();
        while (otp_queue.size() != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

FILE: files.f
rtl/hotp_pkg.sv
rtl/hotp_datapath.sv
rtl/hotp_ctrl.sv
rtl/hotp_hmac_sha1_generator.sv
test/tb_hotp_hmac_sha1_generator.sv
